[src/frac_pll_parameter_solver_assert.svh]
// Assertion macros for the fractional-N PLL parameter solver.
`ifndef FRAC_PLL_PARAMETER_SOLVER_ASSERT_SVH
`define FRAC_PLL_PARAMETER_SOLVER_ASSERT_SVH
`ifndef SYNTH
`define FPPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpps assertion failed");
`define FPPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpps assertion failed");
`else
`define FPPS_ASSERT(lbl, prop)
`define FPPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/fpps_pkg.sv]
// Types, constants and helper functions shared by the PLL solver modules.
package fpps_pkg;

    localparam int NUM_W = 64;
    localparam int DEN_W = 32;
    localparam logic [16:0] BYPASS_WORD = 17'h10000;
    localparam logic [8:0] DIV_CLAMP = 9'd510;
    localparam logic [19:0] HZ_PER_MHZ = 20'd1000000;
    localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;
    localparam int RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        REG_REF_CLOCK = 2'd0,
        REG_REF_DIV   = 2'd1,
        REG_MIN_VCO   = 2'd2,
        REG_MAX_VCO   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_FREF,
        OP_MINC,
        OP_MAXC,
        OP_M,
        OP_FRAC
    } div_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ZCHK,
        S_MUL,
        S_CHECK,
        S_TEST,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    start;
        div_op_t op;
        logic    tenth;
        logic    mul;
        logic    step;
        logic    load_out;
        logic    found;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic zero_case;
        logic c_over;
        logic in_range;
    } status_t;

    function automatic logic [16:0] encode_counter(input logic [32:0] v);
        logic [8:0] vc;
        logic [7:0] hi;
        logic [8:0] lo;
        vc = (v > 33'(DIV_CLAMP)) ? DIV_CLAMP : v[8:0];
        hi = vc[8:1];
        lo = vc - {1'b0, hi};
        if (v < 33'd2) begin
            return BYPASS_WORD;
        end
        return {1'b0, hi, lo[7:0]};
    endfunction

endpackage

[src/fpps_div.sv]
// Restoring serial divider producing one quotient bit per cycle.
module fpps_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fpps_pkg::NUM_W-1:0] num,
    input  logic [fpps_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [fpps_pkg::NUM_W-1:0] quo,
    output logic [fpps_pkg::DEN_W-1:0] rem
);
    import fpps_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = num;
            den_next = den;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            if (!trial[DEN_W]) begin
                rem_next = trial[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;

endmodule

[src/fpps_ctrl.sv]
// Controller state machine sequencing the divider passes and the divider search.
module fpps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  fpps_pkg::status_t status,
    output fpps_pkg::cmd_t    cmd
);
    import fpps_pkg::*;

    state_t  state_reg, state_next;
    div_op_t op_reg, op_next;
    logic    found_reg, found_next;
    logic    rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        cmd.op         = op_reg;
        cmd.found      = found_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid) begin
                    cmd.load_in = 1'b1;
                    op_next     = OP_FREF;
                    found_next  = 1'b0;
                    state_next  = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                cmd.start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done) begin
                    state_next = S_DIV_GO;
                    case (op_reg)
                        OP_FREF: state_next = S_ZCHK;
                        OP_MINC: op_next = OP_MAXC;
                        OP_MAXC: state_next = S_MUL;
                        OP_M:    state_next = S_TEST;
                        OP_FRAC:
                        begin
                            found_next = 1'b1;
                            state_next = S_FINISH;
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_ZCHK:
            begin
                if (status.zero_case) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.tenth  = 1'b1;
                    op_next    = OP_MINC;
                    state_next = S_DIV_GO;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.c_over) begin
                    state_next = S_FINISH;
                end else begin
                    op_next    = OP_M;
                    state_next = S_DIV_GO;
                end
            end
            S_TEST:
            begin
                if (status.in_range) begin
                    op_next    = OP_FRAC;
                    state_next = S_DIV_GO;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall) begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_FREF;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[src/fpps_datapath.sv]
// Datapath holding the configuration, search registers, divider and result registers.
module fpps_datapath #(
    parameter int FRAC_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [27:0]       cfg_data,
    input  logic [29:0]       target_hz,
    input  fpps_pkg::cmd_t    cmd,
    output fpps_pkg::status_t status,
    output logic              found,
    output logic [30:0]       vco_hz,
    output logic [15:0]       m_int,
    output logic [9:0]        c_div,
    output logic [31:0]       m_frac,
    output logic [16:0]       m_word,
    output logic [16:0]       c_word,
    output logic [16:0]       n_word
);
    import fpps_pkg::*;

    logic [27:0] ref_clock_reg;
    logic [8:0]  ref_div_reg;
    logic [10:0] min_vco_reg;
    logic [10:0] max_vco_reg;
    logic [29:0] target_reg;
    logic [27:0] fref_reg, lo_reg, hi_reg, rem_reg;
    logic [32:0] c_reg;
    logic [30:0] maxc_reg;
    logic [31:0] vco_reg, m_reg, frac_reg;
    logic [8:0]  n_eff;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic        div_done;
    logic [NUM_W-1:0] div_quo;
    logic [DEN_W-1:0] div_rem;
    logic [61:0] product;
    logic [30:0] vco_mhz_prod;
    logic [31:0] nine_fref;
    logic [63:0] lo_prod;
    logic [63:0] hi_prod;

    logic        found_reg;
    logic [30:0] vco_out_reg;
    logic [15:0] m_int_reg;
    logic [9:0]  c_div_reg;
    logic [31:0] m_frac_reg;
    logic [16:0] m_word_reg, c_word_reg, n_word_reg;

    assign n_eff = (ref_div_reg == '0) ? 9'd1 : ref_div_reg;

    always_comb
    begin
        vco_mhz_prod = 31'(min_vco_reg) * 31'(HZ_PER_MHZ);
        div_num = NUM_W'(ref_clock_reg);
        div_den = DEN_W'(n_eff);
        case (cmd.op)
            OP_FREF:
            begin
                div_num = NUM_W'(ref_clock_reg);
                div_den = DEN_W'(n_eff);
            end
            OP_MINC:
            begin
                div_num = NUM_W'(vco_mhz_prod) + NUM_W'(target_reg) - NUM_W'(1);
                div_den = DEN_W'(target_reg);
            end
            OP_MAXC:
            begin
                vco_mhz_prod = 31'(max_vco_reg) * 31'(HZ_PER_MHZ);
                div_num = NUM_W'(vco_mhz_prod);
                div_den = DEN_W'(target_reg);
            end
            OP_M:
            begin
                div_num = NUM_W'(vco_reg);
                div_den = DEN_W'(fref_reg);
            end
            OP_FRAC:
            begin
                div_num = NUM_W'(rem_reg) << FRAC_BITS;
                div_den = DEN_W'(fref_reg);
            end
            default:
            begin
                div_num = NUM_W'(ref_clock_reg);
                div_den = DEN_W'(n_eff);
            end
        endcase
    end

    fpps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign product = 62'(c_reg[31:0]) * 62'(target_reg);

    // A tenth of the window bounds by multiplying with the rounded-up reciprocal of ten.
    assign nine_fref = {1'b0, fref_reg, 3'b000} + 32'(fref_reg);
    assign lo_prod   = 64'(fref_reg) * 64'(RECIP_10);
    assign hi_prod   = 64'(nine_fref) * 64'(RECIP_10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ref_clock_reg <= 28'd50000000;
            ref_div_reg   <= 9'd12;
            min_vco_reg   <= 11'd600;
            max_vco_reg   <= 11'd1300;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_REF_CLOCK: ref_clock_reg <= cfg_data;
                REG_REF_DIV:   ref_div_reg   <= cfg_data[8:0];
                REG_MIN_VCO:   min_vco_reg   <= cfg_data[10:0];
                REG_MAX_VCO:   max_vco_reg   <= cfg_data[10:0];
                default:       ref_div_reg   <= ref_div_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in) begin
            target_reg <= target_hz;
        end
        if (cmd.tenth) begin
            lo_reg <= lo_prod[RECIP_SHIFT+27:RECIP_SHIFT];
            hi_reg <= hi_prod[RECIP_SHIFT+27:RECIP_SHIFT];
        end
        if (div_done) begin
            case (cmd.op)
                OP_FREF: fref_reg <= div_quo[27:0];
                OP_MINC: c_reg    <= div_quo[0] ? ({1'b0, div_quo[31:0]} + 33'd1)
                                                : ({1'b0, div_quo[31:0]} + 33'd2);
                OP_MAXC: maxc_reg <= div_quo[30:0];
                OP_M:
                begin
                    m_reg   <= div_quo[31:0];
                    rem_reg <= div_rem[27:0];
                end
                OP_FRAC: frac_reg <= div_quo[31:0];
                default: frac_reg <= frac_reg;
            endcase
        end
        if (cmd.mul) begin
            vco_reg <= product[31:0];
        end
        if (cmd.step) begin
            c_reg   <= c_reg + 33'd2;
            vco_reg <= vco_reg + {1'b0, target_reg, 1'b0};
        end
        if (cmd.load_out) begin
            found_reg   <= cmd.found;
            vco_out_reg <= '0;
            m_int_reg   <= '0;
            c_div_reg   <= '0;
            m_frac_reg  <= '0;
            m_word_reg  <= '0;
            c_word_reg  <= '0;
            n_word_reg  <= '0;
            if (cmd.found) begin
                vco_out_reg <= vco_reg[30:0];
                m_int_reg   <= (m_reg > 32'd65535) ? 16'hFFFF : m_reg[15:0];
                c_div_reg   <= (c_reg > 33'd1023) ? 10'd1023 : c_reg[9:0];
                m_frac_reg  <= frac_reg;
                m_word_reg  <= encode_counter({1'b0, m_reg});
                c_word_reg  <= encode_counter(c_reg);
                n_word_reg  <= encode_counter(33'(n_eff));
            end
        end
    end

    assign status.div_done  = div_done;
    assign status.zero_case = (target_reg == '0) || (fref_reg == '0);
    assign status.c_over    = c_reg > {2'b00, maxc_reg};
    assign status.in_range  = (rem_reg >= lo_reg) && (rem_reg <= hi_reg);

    assign found  = found_reg;
    assign vco_hz = vco_out_reg;
    assign m_int  = m_int_reg;
    assign c_div  = c_div_reg;
    assign m_frac = m_frac_reg;
    assign m_word = m_word_reg;
    assign c_word = c_word_reg;
    assign n_word = n_word_reg;

endmodule

[src/frac_pll_parameter_solver.sv]
// Top level of the fractional-N PLL parameter solver.
// Sequence: three set-up divisions, then one division per even candidate divider tried,
// plus one division for the fraction; one result each.
// Throughput: one transaction at a time, set by the single 64-step serial divider.
// Reset: asynchronous active low; restores the default configuration and clears the response valid.
module frac_pll_parameter_solver #(
    parameter int FRAC_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [27:0] cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [29:0] target_hz,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        found,
    output logic [30:0] vco_hz,
    output logic [15:0] m_int,
    output logic [9:0]  c_div,
    output logic [31:0] m_frac,
    output logic [16:0] m_word,
    output logic [16:0] c_word,
    output logic [16:0] n_word
);
    import fpps_pkg::*;

    `include "frac_pll_parameter_solver_assert.svh"

    cmd_t    cmd;
    status_t status;

    fpps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fpps_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .target_hz (target_hz),
        .cmd       (cmd),
        .status    (status),
        .found     (found),
        .vco_hz    (vco_hz),
        .m_int     (m_int),
        .c_div     (c_div),
        .m_frac    (m_frac),
        .m_word    (m_word),
        .c_word    (c_word),
        .n_word    (n_word)
    );

    `FPPS_ASSERT(a_nofind_zero, rsp_valid && !found |-> vco_hz == '0 && m_int == '0 && c_div == '0)
    `FPPS_ASSERT(a_found_c_even, rsp_valid && found |-> c_word[16] == 1'b0)
    `FPPS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

endmodule

[test/tb_frac_pll_parameter_solver.sv]
// Self-checking testbench for the fractional-N PLL parameter solver.
`timescale 1ns / 1ps

module tb_frac_pll_parameter_solver;
    import fpps_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 50000000;

    typedef struct packed {
        logic        found;
        logic [30:0] vco_hz;
        logic [15:0] m_int;
        logic [9:0]  c_div;
        logic [31:0] m_frac;
        logic [16:0] m_word;
        logic [16:0] c_word;
        logic [16:0] n_word;
    } solution_t;

    class solution_board;
        solution_t pending[$];
        int errors = 0;

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note(solution_t s);
            pending.push_back(s);
        endfunction

        task check(solution_t got);
            solution_t want;
            if (pending.size() == 0)
            begin
                report("result with no outstanding request");
            end
            else
            begin
                want = pending.pop_front();
                if (got.found !== want.found)
                    report($sformatf("found %0d, want %0d", got.found, want.found));
                if (got.vco_hz !== want.vco_hz)
                    report($sformatf("vco_hz %0d, want %0d", got.vco_hz, want.vco_hz));
                if (got.m_int !== want.m_int)
                    report($sformatf("m_int %0d, want %0d", got.m_int, want.m_int));
                if (got.c_div !== want.c_div)
                    report($sformatf("c_div %0d, want %0d", got.c_div, want.c_div));
                if (got.m_frac !== want.m_frac)
                    report($sformatf("m_frac %h, want %h", got.m_frac, want.m_frac));
                if (got.m_word !== want.m_word)
                    report($sformatf("m_word %h, want %h", got.m_word, want.m_word));
                if (got.c_word !== want.c_word)
                    report($sformatf("c_word %h, want %h", got.c_word, want.c_word));
                if (got.n_word !== want.n_word)
                    report($sformatf("n_word %h, want %h", got.n_word, want.n_word));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [27:0] cfg_data;
    logic        req_valid;
    logic        req_stall;
    logic [29:0] target_hz;
    logic        rsp_valid;
    logic        rsp_stall;
    logic        found;
    logic [30:0] vco_hz;
    logic [15:0] m_int;
    logic [9:0]  c_div;
    logic [31:0] m_frac;
    logic [16:0] m_word;
    logic [16:0] c_word;
    logic [16:0] n_word;

    frac_pll_parameter_solver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .target_hz (target_hz),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .found     (found),
        .vco_hz    (vco_hz),
        .m_int     (m_int),
        .c_div     (c_div),
        .m_frac    (m_frac),
        .m_word    (m_word),
        .c_word    (c_word),
        .n_word    (n_word)
    );

    solution_board board;
    longint unsigned ref_clock;
    longint unsigned ref_div;
    longint unsigned vco_min_mhz;
    longint unsigned vco_max_mhz;
    longint unsigned cycles;
    int max_gap;
    int rx_gap;
    int hold_cycles;
    int results_seen;
    bit held;
    logic [29:0] directed[$];

    function automatic logic [16:0] counter_word(longint unsigned v);
        longint unsigned half;
        if (v < 2)
            return BYPASS_WORD;
        if (v > 510)
            v = 510;
        half = v / 2;
        return 17'((half << 8) | (v - half));
    endfunction

    function automatic solution_t solve_dividers(logic [29:0] target);
        solution_t s;
        longint unsigned t, n, fref, min_c, max_c, lo, hi, c, vco, m, rem;
        s = '0;
        t = target;
        n = (ref_div == 0) ? 1 : ref_div;
        fref = ref_clock / n;
        if (t == 0 || fref == 0)
            return s;
        min_c = (vco_min_mhz * 1000000 + t - 1) / t;
        max_c = (vco_max_mhz * 1000000) / t;
        lo = fref / 10;
        hi = (9 * fref) / 10;
        for (c = min_c + 1; c <= max_c; c++)
        begin
            if (c[0])
                continue;
            vco = c * t;
            m = vco / fref;
            rem = vco % fref;
            if (rem < lo || rem > hi)
                continue;
            s.found  = 1'b1;
            s.vco_hz = vco[30:0];
            s.m_int  = (m > 65535) ? 16'hFFFF : m[15:0];
            s.c_div  = (c > 1023) ? 10'd1023 : c[9:0];
            s.m_frac = 32'((rem << 32) / fref);
            s.m_word = counter_word(m);
            s.c_word = counter_word(c);
            s.n_word = counter_word(n);
            return s;
        end
        return s;
    endfunction

    function automatic logic [29:0] random_target();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return 30'($urandom_range(20000000, 650000000));
        if (pick < 9)
            return 30'($urandom_range(1000000, 20000000));
        return 30'($urandom_range(650000000, 30'h3FFFFFFF));
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [27:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_REF_CLOCK: ref_clock = value;
            REG_REF_DIV:   ref_div = value[8:0];
            REG_MIN_VCO:   vco_min_mhz = value[10:0];
            REG_MAX_VCO:   vco_max_mhz = value[10:0];
            default:       ref_clock = ref_clock;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_target(logic [29:0] t);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        target_hz = t;
        do
            @(posedge clk);
        while (req_stall);
        board.note(solve_dividers(t));
        @(negedge clk);
    endtask

    task automatic run_phase(logic [27:0] rclk, logic [27:0] rdiv, logic [27:0] vmin,
                             logic [27:0] vmax, int n_random, int gap_limit);
        req_valid = 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        write_reg(REG_REF_CLOCK, rclk);
        write_reg(REG_REF_DIV, rdiv);
        write_reg(REG_MIN_VCO, vmin);
        write_reg(REG_MAX_VCO, vmax);
        max_gap = gap_limit;
        while (directed.size() != 0)
            send_target(directed.pop_front());
        repeat (n_random) send_target(random_target());
        req_valid = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_frac_pll_parameter_solver: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            board.check({found, vco_hz, m_int, c_div, m_frac, m_word, c_word, n_word});
            results_seen++;
            rx_gap = $urandom_range(0, max_gap);
            if (results_seen == 4 && !held)
            begin
                held = 1'b1;
                hold_cycles = 3000;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_stall = 1'b1;
            hold_cycles--;
        end
        else if (rx_gap > 0)
        begin
            rsp_stall = 1'b1;
            rx_gap--;
        end
        else
        begin
            rsp_stall = 1'b0;
        end
    end

    initial
    begin
        board = new();
        cycles = 0;
        results_seen = 0;
        held = 1'b0;
        hold_cycles = 0;
        rx_gap = 0;
        max_gap = 12;
        ref_clock = 50000000;
        ref_div = 12;
        vco_min_mhz = 600;
        vco_max_mhz = 1300;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_REF_CLOCK;
        cfg_data = '0;
        req_valid = 1'b0;
        target_hz = '0;
        rsp_stall = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed = '{30'd0, 30'd1000000, 30'd650000000, 30'h3FFFFFFF, 30'd25000000,
                     30'd100000000, 30'd333333333, 30'd1234567, 30'd47000000};
        run_phase(28'd50000000, 28'd12, 28'd600, 28'd1300, 6, 12);
        directed = '{30'd1000000, 30'd650000000};
        run_phase(28'd200000000, 28'd1, 28'd1, 28'd2000, 8, 12);
        directed = '{30'd1000000, 30'd3000000};
        run_phase(28'd1000000, 28'd510, 28'd1, 28'd2000, 5, 0);
        directed = '{30'd1000000};
        run_phase(28'd1000000, 28'd510, 28'd1100, 28'd2000, 2, 12);
        directed = '{30'd1000000, 30'd650000000};
        run_phase(28'hFFFFFFF, 28'd0, 28'd2047, 28'd2047, 4, 12);
        directed = '{30'd1000000};
        run_phase(28'd0, 28'd12, 28'd600, 28'd1300, 2, 12);
        directed = '{30'd1000000};
        run_phase(28'd100, 28'd511, 28'd600, 28'd1300, 2, 12);
        directed = '{30'd1, 30'd0};
        run_phase(28'd50000000, 28'd12, 28'd1, 28'd1, 0, 12);
        run_phase(28'd27000000, 28'd3, 28'd600, 28'd1600, 25, 0);
        run_phase(28'd50000000, 28'd12, 28'd600, 28'd1300, 30, 12);

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("tb_frac_pll_parameter_solver: done, clean");
        else
            $display("tb_frac_pll_parameter_solver: done, errors");
        $finish;
    end

endmodule
